>>> rtl/core/btndb_pkg.sv
// Shared constants and types for the button debouncer with reset combination.
package btndb_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int BTN_W        = 4;
    localparam int DEB_W        = 8;
    localparam int HOLD_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_MASK       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_ENABLE     = 3'd4;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET  = 8'd20;
    localparam logic [HOLD_W-1:0] THRESHOLD_RESET = 16'd2440;
    localparam logic [BTN_W-1:0]  COMBO_RESET     = 4'd5;
    localparam logic [BTN_W-1:0]  RECOVERY_RESET  = 4'd2;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = {HOLD_W{1'b1}};

    typedef struct packed {
        logic press;
        logic rel;
        logic stable;
        logic differ;
    } lane_out_t;

    typedef struct packed {
        logic [BTN_W-1:0] press;
        logic [BTN_W-1:0] rel;
        logic [BTN_W-1:0] stable;
        logic             still_active;
        logic             reset_request;
        logic             recovery_boot;
    } result_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_threshold;
        logic [BTN_W-1:0]  combo_mask;
        logic [BTN_W-1:0]  recovery_mask;
        logic              combo_enable;
    } combo_cfg_t;

endpackage

>>> rtl/core/btndb_lane.sv
// One debounce lane: mismatch counter and debounced level of a single button.
module btndb_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      raw_bit,
    input  logic [btndb_pkg::DEB_W-1:0] debounce_samples,
    output btndb_pkg::lane_out_t      lane_out
);
    import btndb_pkg::*;

    logic [DEB_W-1:0] count_reg;
    logic [DEB_W-1:0] count_next;
    logic             stable_reg;
    logic             stable_next;
    logic [DEB_W-1:0] count_inc;
    logic             differ;
    logic             hit;

    assign differ    = raw_bit != stable_reg;
    assign count_inc = count_reg + 1'b1;
    assign hit       = differ && (count_inc == debounce_samples);

    always_comb
    begin
        count_next  = '0;
        stable_next = stable_reg;
        if (differ && !hit)
        begin
            count_next = count_inc;
        end
        if (hit)
        begin
            stable_next = raw_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            stable_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            stable_reg <= stable_next;
        end
    end

    assign lane_out.press  = hit && raw_bit;
    assign lane_out.rel    = hit && !raw_bit;
    assign lane_out.stable = stable_next;
    assign lane_out.differ = differ;

endmodule

>>> rtl/core/btndb_merge.sv
// Merging stage: combines lane results and runs the reset combination hold counter.
module btndb_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [btndb_pkg::BTN_W-1:0] press,
    input  logic [btndb_pkg::BTN_W-1:0] rel,
    input  logic [btndb_pkg::BTN_W-1:0] stable,
    input  logic [btndb_pkg::BTN_W-1:0] differ,
    input  btndb_pkg::combo_cfg_t       cfg,
    output btndb_pkg::result_t          result
);
    import btndb_pkg::*;

    logic [HOLD_W-1:0] hold_count_reg;
    logic [HOLD_W-1:0] hold_count_next;
    logic              held;
    logic              req;

    assign held = cfg.combo_enable && ((stable & cfg.combo_mask) == cfg.combo_mask);

    always_comb
    begin
        hold_count_next = '0;
        if (held)
        begin
            hold_count_next = (hold_count_reg == HOLD_MAX) ? hold_count_reg
                                                           : hold_count_reg + 1'b1;
        end
    end

    assign req = held && (hold_count_next > cfg.hold_threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg <= '0;
        end
        else if (accept)
        begin
            hold_count_reg <= hold_count_next;
        end
    end

    assign result.press         = press;
    assign result.rel           = rel;
    assign result.stable        = stable;
    assign result.still_active  = (|differ) || held;
    assign result.reset_request = req;
    assign result.recovery_boot = req && (|(stable & cfg.recovery_mask));

    a_recovery_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        result.recovery_boot |-> result.reset_request)
        else $error("recovery flagged without reset request");

    a_request_keeps_active: assert property (@(posedge clk) disable iff (!rst_n)
        result.reset_request |-> result.still_active)
        else $error("reset request without activity");

    a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && held && hold_count_reg == HOLD_MAX) |=> hold_count_reg == HOLD_MAX)
        else $error("hold counter wrapped past its maximum");

endmodule

>>> rtl/core/btndb_outq.sv
// Two-entry output queue that decouples the sample side from the result side.
module btndb_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  btndb_pkg::result_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output btndb_pkg::result_t out_data
);
    import btndb_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full      = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/button_debouncer_with_reset_combo.sv
// Top level of the button debouncer with reset combination detection.
// One sample request is taken per clock cycle: all button lanes update their
// counters side by side in that cycle and the merging stage derives the hold
// counter and reset request in the same cycle, so an accepted sample's result
// enters a two-entry output queue at the next edge. The queue lets sampling go
// on while one result waits; in_stall rises only when both entries are waiting.
// Configuration writes are always ready and take effect on the next sample.
module button_debouncer_with_reset_combo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [btndb_pkg::BTN_W-1:0]      raw_buttons,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [btndb_pkg::BTN_W-1:0]      press_events,
    output logic [btndb_pkg::BTN_W-1:0]      release_events,
    output logic [btndb_pkg::BTN_W-1:0]      stable_buttons,
    output logic                             still_active,
    output logic                             reset_request,
    output logic                             recovery_boot,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btndb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btndb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import btndb_pkg::*;

    logic [DEB_W-1:0]  debounce_samples_reg;
    logic [HOLD_W-1:0] hold_threshold_reg;
    logic [BTN_W-1:0]  combo_mask_reg;
    logic [BTN_W-1:0]  recovery_mask_reg;
    logic              combo_enable_reg;

    logic              accept;
    logic              full;
    logic [BTN_W-1:0]  press;
    logic [BTN_W-1:0]  rel;
    logic [BTN_W-1:0]  stable;
    logic [BTN_W-1:0]  differ;
    combo_cfg_t        combo_cfg;
    result_t           result;
    result_t           out_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_samples_reg <= DEBOUNCE_RESET;
            hold_threshold_reg   <= THRESHOLD_RESET;
            combo_mask_reg       <= COMBO_RESET;
            recovery_mask_reg    <= RECOVERY_RESET;
            combo_enable_reg     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_data[DEB_W-1:0];
                REG_HOLD_THRESHOLD:   hold_threshold_reg   <= cfg_data[HOLD_W-1:0];
                REG_COMBO_MASK:       combo_mask_reg       <= cfg_data[BTN_W-1:0];
                REG_RECOVERY_MASK:    recovery_mask_reg    <= cfg_data[BTN_W-1:0];
                REG_COMBO_ENABLE:     combo_enable_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    for (genvar i = 0; i < BTN_W; i++)
    begin : g_lane
        if (i < BUTTON_COUNT)
        begin : g_used
            lane_out_t lane_out;

            btndb_lane u_lane (
                .clk              (clk),
                .rst_n            (rst_n),
                .accept           (accept),
                .raw_bit          (raw_buttons[i]),
                .debounce_samples (debounce_samples_reg),
                .lane_out         (lane_out)
            );

            assign press[i]  = lane_out.press;
            assign rel[i]    = lane_out.rel;
            assign stable[i] = lane_out.stable;
            assign differ[i] = lane_out.differ;
        end
        else
        begin : g_unused
            assign press[i]  = 1'b0;
            assign rel[i]    = 1'b0;
            assign stable[i] = 1'b0;
            assign differ[i] = 1'b0;
        end
    end

    assign combo_cfg.hold_threshold = hold_threshold_reg;
    assign combo_cfg.combo_mask     = combo_mask_reg;
    assign combo_cfg.recovery_mask  = recovery_mask_reg;
    assign combo_cfg.combo_enable   = combo_enable_reg;

    btndb_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .press  (press),
        .rel    (rel),
        .stable (stable),
        .differ (differ),
        .cfg    (combo_cfg),
        .result (result)
    );

    btndb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign press_events   = out_data.press;
    assign release_events = out_data.rel;
    assign stable_buttons = out_data.stable;
    assign still_active   = out_data.still_active;
    assign reset_request  = out_data.reset_request;
    assign recovery_boot  = out_data.recovery_boot;

endmodule
